[rtl/hsc_pkg.sv]
// Shared types, constants and code-construction functions for the Hamming SEC codec.
`timescale 1ns / 1ps
package hsc_pkg;

  localparam int WORD_W              = 64;  // width of the word ports
  localparam int SYN_W               = 7;   // width of the syndrome port
  localparam int DBITS_W             = 6;   // width of the data length register
  localparam int LEN_W               = 7;   // holds a code length up to 64
  localparam int DEF_MAX_CODE_BITS   = 64;
  localparam int DEF_MAX_PARITY_BITS = 7;

  localparam logic [DBITS_W-1:0] DATA_BITS_RST = 6'd8;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  // Control that travels alongside each pipeline stage
  typedef struct packed {
    logic valid;
    op_t  op;
  } stage_ctl_t;

  // Least r with 2^r >= m + r + 1
  function automatic int parity_count(int m);
    int r;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if (m + r + 1 > (1 << r)) r++;
    end
    return r;
  endfunction

  // Largest data length that fits the code and parity limits
  function automatic int max_data_bits(int max_code, int max_par);
    int best;
    best = 1;
    for (int m = 1; m < 64; m++) begin
      if ((m + parity_count(m) <= max_code) && (parity_count(m) <= max_par)) best = m;
    end
    return best;
  endfunction

  // Code length n for a register value, with zero taken as one and saturation
  function automatic logic [LEN_W-1:0] code_len_of(logic [DBITS_W-1:0] dbits, int mmax);
    int m;
    m = (dbits == '0) ? 1 : int'(dbits);
    if (m > mmax) m = mmax;
    return LEN_W'(m + parity_count(m));
  endfunction

  // Data bit index carried at a non-power-of-two position p (1-based)
  function automatic int data_index(int p);
    int lg;
    lg = 0;
    for (int i = 0; i < 7; i++) begin
      if ((1 << (i + 1)) <= p) lg = i + 1;
    end
    return p - 2 - lg;
  endfunction

  // Positions (bit p-1) whose index has bit k set
  function automatic logic [WORD_W-1:0] cover_mask(int k);
    logic [WORD_W-1:0] msk;
    msk = '0;
    for (int p = 1; p <= WORD_W; p++) begin
      msk[p-1] = ((p >> k) & 1) != 0;
    end
    return msk;
  endfunction

endpackage

[rtl/hamming_sec_codec.sv]
// Top level of the Hamming single-error-correcting codec.
`timescale 1ns / 1ps
// Hamming SEC encoder/decoder, no overall parity bit. One item is taken every cycle
// (busy stays low) and its result appears on out_* with out_strobe after passing through the
// register stages of placement, parity trees and correction, each of which owns one.
// Results are not held; the receiver must take each one in its strobe cycle.
// cfg_data_bits sets the data length m (zero reads as one, large values saturate to what
// fits MAX_CODE_BITS and MAX_PARITY_BITS); write it only with the pipeline empty.
// Codeword position p sits at bit p-1; bits at and above the code length come out zero.
module hamming_sec_codec #(
  parameter int MAX_CODE_BITS   = hsc_pkg::DEF_MAX_CODE_BITS,
  parameter int MAX_PARITY_BITS = hsc_pkg::DEF_MAX_PARITY_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [hsc_pkg::DBITS_W-1:0] cfg_data_bits,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_operation,
  input  logic [hsc_pkg::WORD_W-1:0]  in_word_in,
  output logic                        out_strobe,
  output logic [hsc_pkg::WORD_W-1:0]  out_word_out,
  output logic [hsc_pkg::SYN_W-1:0]   out_syndrome,
  output logic                        out_corrected,
  output logic                        out_bad_syndrome
);
  import hsc_pkg::*;

  logic [LEN_W-1:0]           code_len;
  stage_ctl_t                 in_ctl;
  stage_ctl_t                 s1_ctl;
  stage_ctl_t                 s2_ctl;
  logic [MAX_CODE_BITS-1:0]   s1_word;
  logic [MAX_CODE_BITS-1:0]   s2_word;
  logic [MAX_PARITY_BITS-1:0] s2_syn;

  // Fully pipelined, never stalls
  assign busy = 1'b0;

  assign in_ctl.valid = start && !busy;
  assign in_ctl.op    = op_t'(in_operation);

  hsc_cfg #(
    .MAX_CODE_BITS  (MAX_CODE_BITS),
    .MAX_PARITY_BITS(MAX_PARITY_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data_bits(cfg_data_bits),
    .code_len     (code_len)
  );

  hsc_place #(
    .CODE_W(MAX_CODE_BITS)
  ) u_place (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (in_ctl),
    .word_in (in_word_in),
    .code_len(code_len),
    .ctl_r   (s1_ctl),
    .word_r  (s1_word)
  );

  hsc_syndrome #(
    .CODE_W(MAX_CODE_BITS),
    .PAR_W (MAX_PARITY_BITS)
  ) u_syndrome (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_in (s1_ctl),
    .word_in(s1_word),
    .ctl_r  (s2_ctl),
    .word_r (s2_word),
    .syn_r  (s2_syn)
  );

  hsc_correct #(
    .CODE_W(MAX_CODE_BITS),
    .PAR_W (MAX_PARITY_BITS)
  ) u_correct (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl_in          (s2_ctl),
    .word_in         (s2_word),
    .syn_in          (s2_syn),
    .code_len        (code_len),
    .out_strobe      (out_strobe),
    .out_word_out    (out_word_out),
    .out_syndrome    (out_syndrome),
    .out_corrected   (out_corrected),
    .out_bad_syndrome(out_bad_syndrome)
  );

  // Every result comes from an earlier transfer
  a_strobe_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 3))
    else $error("result strobe without a matching transfer");

  // A transfer with reset held off yields a result
  a_transfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(start && !busy, 3) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1))
      |-> out_strobe)
    else $error("transfer lost in the pipeline");

  // A correction names a real position and never coincides with a bad syndrome
  a_corrected_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_corrected) |->
      (!out_bad_syndrome && (out_syndrome != '0) && (LEN_W'(out_syndrome) <= code_len)))
    else $error("correction flag inconsistent with syndrome");

  // Nothing is set at or above the code length
  a_word_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_word_out >> code_len) == '0))
    else $error("codeword bits set beyond code length");

endmodule

[rtl/hsc_cfg.sv]
// Data length register; keeps the derived code length ready for the datapath.
`timescale 1ns / 1ps
module hsc_cfg #(
  parameter int MAX_CODE_BITS   = hsc_pkg::DEF_MAX_CODE_BITS,
  parameter int MAX_PARITY_BITS = hsc_pkg::DEF_MAX_PARITY_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [hsc_pkg::DBITS_W-1:0] cfg_data_bits,
  output logic [hsc_pkg::LEN_W-1:0]   code_len
);
  import hsc_pkg::*;

  localparam int MMAX = max_data_bits(MAX_CODE_BITS, MAX_PARITY_BITS);

  logic [LEN_W-1:0] code_len_r;
  logic [LEN_W-1:0] code_len_nxt;

  // Work out n at write time so items see it from the next cycle
  always_comb begin
    code_len_nxt = code_len_r;
    if (cfg_we) begin
      code_len_nxt = code_len_of(cfg_data_bits, MMAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_len_r <= code_len_of(DATA_BITS_RST, MMAX);
    end else begin
      code_len_r <= code_len_nxt;
    end
  end

  assign code_len = code_len_r;

endmodule

[rtl/hsc_place.sv]
// Stage 1: scatter data bits to codeword positions, or take the codeword, masked to n.
`timescale 1ns / 1ps
module hsc_place #(
  parameter int CODE_W = hsc_pkg::DEF_MAX_CODE_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hsc_pkg::stage_ctl_t        ctl_in,
  input  logic [hsc_pkg::WORD_W-1:0] word_in,
  input  logic [hsc_pkg::LEN_W-1:0]  code_len,
  output hsc_pkg::stage_ctl_t        ctl_r,
  output logic [CODE_W-1:0]          word_r
);
  import hsc_pkg::*;

  logic [CODE_W-1:0] scat;
  logic [CODE_W-1:0] in_range;
  logic [CODE_W-1:0] word_nxt;

  // Fixed wiring: powers of two stay empty for the parity bits
  for (genvar p = 1; p <= CODE_W; p++) begin : g_pos
    if ((p & (p - 1)) == 0) begin : g_par
      assign scat[p-1] = 1'b0;
    end else begin : g_dat
      localparam int J = data_index(p);
      assign scat[p-1] = word_in[J];
    end
    assign in_range[p-1] = (LEN_W'(p) <= code_len);
  end

  always_comb begin
    if (ctl_in.op == OP_DECODE) begin
      word_nxt = word_in[CODE_W-1:0] & in_range;
    end else begin
      word_nxt = scat & in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

[rtl/hsc_syndrome.sv]
// Stage 2: parity trees, one per syndrome bit, over the masked codeword.
`timescale 1ns / 1ps
module hsc_syndrome #(
  parameter int CODE_W = hsc_pkg::DEF_MAX_CODE_BITS,
  parameter int PAR_W  = hsc_pkg::DEF_MAX_PARITY_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hsc_pkg::stage_ctl_t ctl_in,
  input  logic [CODE_W-1:0]   word_in,
  output hsc_pkg::stage_ctl_t ctl_r,
  output logic [CODE_W-1:0]   word_r,
  output logic [PAR_W-1:0]    syn_r
);
  import hsc_pkg::*;

  logic [PAR_W-1:0] syn_nxt;

  // Syndrome bit k is the XOR of all positions whose index has bit k set
  for (genvar k = 0; k < PAR_W; k++) begin : g_syn
    localparam logic [CODE_W-1:0] COVER = CODE_W'(cover_mask(k));
    assign syn_nxt[k] = ^(word_in & COVER);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_in;
    syn_r  <= syn_nxt;
  end

endmodule

[rtl/hsc_correct.sv]
// Stage 3: insert parity bits or flip the named bit, and register the result.
`timescale 1ns / 1ps
module hsc_correct #(
  parameter int CODE_W = hsc_pkg::DEF_MAX_CODE_BITS,
  parameter int PAR_W  = hsc_pkg::DEF_MAX_PARITY_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hsc_pkg::stage_ctl_t        ctl_in,
  input  logic [CODE_W-1:0]          word_in,
  input  logic [PAR_W-1:0]           syn_in,
  input  logic [hsc_pkg::LEN_W-1:0]  code_len,
  output logic                       out_strobe,
  output logic [hsc_pkg::WORD_W-1:0] out_word_out,
  output logic [hsc_pkg::SYN_W-1:0]  out_syndrome,
  output logic                       out_corrected,
  output logic                       out_bad_syndrome
);
  import hsc_pkg::*;

  logic [CODE_W-1:0] flip_vec;
  logic [CODE_W-1:0] par_vec;
  logic              bad;
  logic              is_dec;

  logic              strobe_r;
  logic [CODE_W-1:0] word_r,  word_nxt;
  logic [SYN_W-1:0]  syn_r,   syn_nxt;
  logic              corr_r,  corr_nxt;
  logic              bad_r,   bad_nxt;

  // One-hot of the syndrome, and parity bits dropped on power-of-two positions
  for (genvar p = 1; p <= CODE_W; p++) begin : g_pos
    assign flip_vec[p-1] = (LEN_W'(syn_in) == LEN_W'(p));
    if ((p & (p - 1)) == 0) begin : g_par
      localparam int K = $clog2(p);
      if (K < PAR_W) begin : g_use
        assign par_vec[p-1] = syn_in[K];
      end else begin : g_none
        assign par_vec[p-1] = 1'b0;
      end
    end else begin : g_dat
      assign par_vec[p-1] = 1'b0;
    end
  end

  assign is_dec = (ctl_in.op == OP_DECODE);
  assign bad    = LEN_W'(syn_in) > code_len;

  always_comb begin
    if (is_dec) begin
      word_nxt = bad ? word_in : (word_in ^ flip_vec);
      syn_nxt  = SYN_W'(syn_in);
      corr_nxt = !bad && (syn_in != '0);
      bad_nxt  = bad;
    end else begin
      word_nxt = word_in | par_vec;
      syn_nxt  = '0;
      corr_nxt = 1'b0;
      bad_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    syn_r  <= syn_nxt;
    corr_r <= corr_nxt;
    bad_r  <= bad_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_word_out     = WORD_W'(word_r);
  assign out_syndrome     = syn_r;
  assign out_corrected    = corr_r;
  assign out_bad_syndrome = bad_r;

endmodule
